// ===== rtl/wsps_pkg.sv =====
// Package for the weighted sensor PD steering block.
// Holds field widths, register indexes, weight tables and servo constants.
// No dependencies.
package wsps_pkg;

    localparam int SAMPLE_WIDTH    = 12;
    localparam int COUNT_WIDTH     = 11;
    localparam int ERROR_WIDTH     = 11;
    localparam int GAIN_WIDTH      = 10;
    localparam int SPEED_WIDTH     = 8;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 12;

    localparam int DIVIDEND_WIDTH  = 22;
    localparam int DIVISOR_WIDTH   = 14;

    localparam int COUNT_NEUTRAL   = 750;
    localparam int SPEED_LIMIT     = 100;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TRACE_MODE     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LINE_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P         = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D         = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_SPEED     = 3'd4;

    localparam logic                     RESET_TRACE_MODE     = 1'b1;
    localparam logic [SAMPLE_WIDTH-1:0]  RESET_LINE_THRESHOLD = 12'd1000;
    localparam logic [GAIN_WIDTH-1:0]    RESET_GAIN_P         = 10'd384;
    localparam logic [GAIN_WIDTH-1:0]    RESET_GAIN_D         = 10'd128;
    localparam logic [SPEED_WIDTH-1:0]   RESET_BASE_SPEED     = 8'd10;

    localparam logic TRACE_LINE = 1'b0;

    localparam logic signed [3:0] LINE_WEIGHTS [4] = '{4'sd3, 4'sd1, -4'sd1, -4'sd3};
    localparam logic signed [3:0] WALL_WEIGHTS [4] = '{-4'sd1, -4'sd3, 4'sd3, 4'sd1};

endpackage

// ===== rtl/wsps_divider.sv =====
// Restoring unsigned divider that resolves one quotient bit per cycle.
// Depends on wsps_pkg for its default widths.
module wsps_divider
    import wsps_pkg::*;
#(
    parameter int DividendWidth = DIVIDEND_WIDTH,
    parameter int DivisorWidth  = DIVISOR_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DividendWidth-1:0] dividend,
    input  logic [DivisorWidth-1:0]  divisor,
    output logic                     done,
    output logic [DividendWidth-1:0] quotient
);

    localparam int CountWidth = $clog2(DividendWidth + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CountWidth-1:0]    count_reg, count_next;
    logic [DividendWidth-1:0] quot_reg, quot_next;
    logic [DivisorWidth-1:0]  rem_reg, rem_next;
    logic [DivisorWidth-1:0]  divisor_reg, divisor_next;
    logic [DivisorWidth+1:0]  trial;

    assign trial = {1'b0, rem_reg, quot_reg[DividendWidth-1]} - {2'b00, divisor_reg};

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            count_next   = CountWidth'(DividendWidth);
            quot_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end else if (busy_reg) begin
            quot_next  = {quot_reg[DividendWidth-2:0], ~trial[DivisorWidth+1]};
            rem_next   = trial[DivisorWidth+1] ? {rem_reg[DivisorWidth-2:0],
                                                  quot_reg[DividendWidth-1]}
                                               : trial[DivisorWidth-1:0];
            count_next = count_reg - CountWidth'(1);
            if (count_reg == CountWidth'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("Divider finished without having been busy.");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !$past(start) |-> rem_reg < divisor_reg)
        else $error("Partial remainder reached the divisor.");

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("Divider started while busy.");

endmodule

// ===== rtl/weighted_sensor_pd_steering.sv =====
// A halted transfer goes from the load step straight to the done step; a steering transfer
// passes through load, divide, P and D multiply, accumulate, speed and done, and its divide
// step runs the 22 bit-serial steps of the divider. A tick whose weight total is zero skips
// the divider. One transfer is in flight at a time; the next is accepted while a result waits.
// Reset is synchronous and active low; it restores the register defaults and clears
// the previous error.
module weighted_sensor_pd_steering
    import wsps_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [SAMPLE_WIDTH-1:0]        s_sample_0,
    input  logic [SAMPLE_WIDTH-1:0]        s_sample_1,
    input  logic [SAMPLE_WIDTH-1:0]        s_sample_2,
    input  logic [SAMPLE_WIDTH-1:0]        s_sample_3,
    input  logic                           s_halt,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [COUNT_WIDTH-1:0]         m_left_count,
    output logic [COUNT_WIDTH-1:0]         m_right_count,
    output logic signed [ERROR_WIDTH-1:0]  m_position_error,
    output logic                           m_target_lost
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LOAD   = 8'b0000_0010,
        ST_DIVIDE = 8'b0000_0100,
        ST_MUL_P  = 8'b0000_1000,
        ST_MUL_D  = 8'b0001_0000,
        ST_ACCUM  = 8'b0010_0000,
        ST_SPEED  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic                          trace_mode_reg, trace_mode_next;
    logic [SAMPLE_WIDTH-1:0]       line_threshold_reg, line_threshold_next;
    logic [GAIN_WIDTH-1:0]         gain_p_reg, gain_p_next;
    logic [GAIN_WIDTH-1:0]         gain_d_reg, gain_d_next;
    logic signed [SPEED_WIDTH-1:0] base_speed_reg, base_speed_next;

    logic signed [ERROR_WIDTH-1:0] prev_error_reg, prev_error_next;
    logic                          m_valid_reg, m_valid_next;

    logic signed [15:0]            sum_val_reg, sum_val_next;
    logic [DIVISOR_WIDTH-1:0]      sum_weight_reg, sum_weight_next;
    logic                          halt_reg, halt_next;
    logic                          lost_reg, lost_next;
    logic signed [ERROR_WIDTH-1:0] err_reg, err_next;
    logic signed [22:0]            prod_reg, prod_next;
    logic signed [23:0]            acc_reg, acc_next;
    logic signed [25:0]            sum_l_reg, sum_l_next;
    logic signed [25:0]            sum_r_reg, sum_r_next;

    logic [COUNT_WIDTH-1:0]        left_count_reg, left_count_next;
    logic [COUNT_WIDTH-1:0]        right_count_reg, right_count_next;
    logic signed [ERROR_WIDTH-1:0] out_error_reg, out_error_next;
    logic                          out_lost_reg, out_lost_next;

    logic [SAMPLE_WIDTH-1:0]       samples [4];
    logic signed [15:0]            sum_val_c;
    logic [DIVISOR_WIDTH-1:0]      sum_weight_c;

    logic                          div_start;
    logic                          div_done;
    logic [DIVIDEND_WIDTH-1:0]     div_dividend;
    logic [DIVIDEND_WIDTH-1:0]     div_quotient;
    logic [13:0]                   sum_mag;

    logic signed [10:0]            mul_a;
    logic signed [11:0]            mul_b;
    logic signed [22:0]            mul_out;
    logic signed [11:0]            deriv;
    logic signed [ERROR_WIDTH-1:0] quot_signed;

    logic signed [SPEED_WIDTH-1:0] speed_l;
    logic signed [SPEED_WIDTH-1:0] speed_r;
    logic signed [11:0]            count_l;
    logic signed [11:0]            count_r;
    logic                          s_accept;
    logic                          out_free;

    function automatic logic signed [SPEED_WIDTH-1:0] to_speed(
        input logic signed [25:0] q16
    );
        logic signed [10:0] q;
        q = 11'(q16 >>> 16);
        if (q16[25] && (q16[15:0] != 16'd0)) begin
            q = q + 11'sd1;
        end
        if (q > 11'(SPEED_LIMIT)) begin
            q = 11'(SPEED_LIMIT);
        end else if (q < -11'(SPEED_LIMIT)) begin
            q = -11'(SPEED_LIMIT);
        end
        return SPEED_WIDTH'(q);
    endfunction

    assign samples[0] = s_sample_0;
    assign samples[1] = s_sample_1;
    assign samples[2] = s_sample_2;
    assign samples[3] = s_sample_3;

    always_comb begin
        logic [SAMPLE_WIDTH-1:0] inv;
        sum_val_c    = '0;
        sum_weight_c = '0;
        for (int i = 0; i < 4; i++) begin
            inv = ~samples[i];
            if (trace_mode_reg == TRACE_LINE) begin
                if (samples[i] > line_threshold_reg) begin
                    sum_val_c    = sum_val_c + 16'(LINE_WEIGHTS[i]);
                    sum_weight_c = sum_weight_c + DIVISOR_WIDTH'(1);
                end
            end else begin
                sum_val_c    = sum_val_c + signed'({4'b0000, inv}) * 16'(WALL_WEIGHTS[i]);
                sum_weight_c = sum_weight_c + DIVISOR_WIDTH'(inv);
            end
        end
    end

    assign sum_mag      = sum_val_reg[15] ? 14'(-sum_val_reg) : sum_val_reg[13:0];
    assign div_dividend = {sum_mag, 8'b0000_0000};
    assign div_start    = (state_reg == ST_LOAD) && !halt_reg && (sum_weight_reg != '0);
    assign quot_signed  = signed'({1'b0, div_quotient[9:0]});

    wsps_divider #(
        .DividendWidth(DIVIDEND_WIDTH),
        .DivisorWidth (DIVISOR_WIDTH)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (sum_weight_reg),
        .done    (div_done),
        .quotient(div_quotient)
    );

    assign deriv   = 12'(err_reg) - 12'(prev_error_reg);
    assign mul_a   = (state_reg == ST_MUL_P) ? signed'({1'b0, gain_p_reg})
                                             : signed'({1'b0, gain_d_reg});
    assign mul_b   = (state_reg == ST_MUL_P) ? 12'(err_reg) : deriv;
    assign mul_out = mul_a * mul_b;

    assign speed_l = to_speed(sum_l_reg);
    assign speed_r = to_speed(sum_r_reg);
    assign count_l = 12'(COUNT_NEUTRAL) + 12'(signed'({speed_l, 2'b00}));
    assign count_r = 12'(COUNT_NEUTRAL) - 12'(signed'({speed_r, 2'b00}));

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next          = state_reg;
        trace_mode_next     = trace_mode_reg;
        line_threshold_next = line_threshold_reg;
        gain_p_next         = gain_p_reg;
        gain_d_next         = gain_d_reg;
        base_speed_next     = base_speed_reg;
        prev_error_next     = prev_error_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        sum_val_next        = sum_val_reg;
        sum_weight_next     = sum_weight_reg;
        halt_next           = halt_reg;
        lost_next           = lost_reg;
        err_next            = err_reg;
        prod_next           = prod_reg;
        acc_next            = acc_reg;
        sum_l_next          = sum_l_reg;
        sum_r_next          = sum_r_reg;
        left_count_next     = left_count_reg;
        right_count_next    = right_count_reg;
        out_error_next      = out_error_reg;
        out_lost_next       = out_lost_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TRACE_MODE:     trace_mode_next     = cfg_wdata[0];
                REG_LINE_THRESHOLD: line_threshold_next = cfg_wdata;
                REG_GAIN_P:         gain_p_next         = cfg_wdata[GAIN_WIDTH-1:0];
                REG_GAIN_D:         gain_d_next         = cfg_wdata[GAIN_WIDTH-1:0];
                REG_BASE_SPEED:     base_speed_next     = signed'(cfg_wdata[SPEED_WIDTH-1:0]);
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sum_val_next    = sum_val_c;
                    sum_weight_next = sum_weight_c;
                    halt_next       = s_halt;
                    state_next      = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (halt_reg) begin
                    state_next = ST_DONE;
                end else if (sum_weight_reg == '0) begin
                    err_next   = prev_error_reg;
                    lost_next  = 1'b1;
                    state_next = ST_MUL_P;
                end else begin
                    lost_next  = 1'b0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    err_next   = sum_val_reg[15] ? -quot_signed : quot_signed;
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                prod_next  = mul_out;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                prod_next  = mul_out;
                acc_next   = 24'(prod_reg);
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                acc_next   = acc_reg + 24'(prod_reg);
                state_next = ST_SPEED;
            end
            ST_SPEED: begin
                sum_l_next = signed'({{2{base_speed_reg[SPEED_WIDTH-1]}}, base_speed_reg, 16'h0000})
                             + 26'(acc_reg);
                sum_r_next = signed'({{2{base_speed_reg[SPEED_WIDTH-1]}}, base_speed_reg, 16'h0000})
                             - 26'(acc_reg);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (halt_reg) begin
                        left_count_next  = COUNT_WIDTH'(COUNT_NEUTRAL);
                        right_count_next = COUNT_WIDTH'(COUNT_NEUTRAL);
                        out_error_next   = prev_error_reg;
                        out_lost_next    = 1'b0;
                    end else begin
                        left_count_next  = count_l[COUNT_WIDTH-1:0];
                        right_count_next = count_r[COUNT_WIDTH-1:0];
                        out_error_next   = err_reg;
                        out_lost_next    = lost_reg;
                        prev_error_next  = err_reg;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            trace_mode_reg     <= RESET_TRACE_MODE;
            line_threshold_reg <= RESET_LINE_THRESHOLD;
            gain_p_reg         <= RESET_GAIN_P;
            gain_d_reg         <= RESET_GAIN_D;
            base_speed_reg     <= signed'(RESET_BASE_SPEED);
            prev_error_reg     <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            trace_mode_reg     <= trace_mode_next;
            line_threshold_reg <= line_threshold_next;
            gain_p_reg         <= gain_p_next;
            gain_d_reg         <= gain_d_next;
            base_speed_reg     <= base_speed_next;
            prev_error_reg     <= prev_error_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_val_reg     <= sum_val_next;
        sum_weight_reg  <= sum_weight_next;
        halt_reg        <= halt_next;
        lost_reg        <= lost_next;
        err_reg         <= err_next;
        prod_reg        <= prod_next;
        acc_reg         <= acc_next;
        sum_l_reg       <= sum_l_next;
        sum_r_reg       <= sum_r_next;
        left_count_reg  <= left_count_next;
        right_count_reg <= right_count_next;
        out_error_reg   <= out_error_next;
        out_lost_reg    <= out_lost_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_left_count     = left_count_reg;
    assign m_right_count    = right_count_reg;
    assign m_position_error = out_error_reg;
    assign m_target_lost    = out_lost_reg;

    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("Divider finished outside the divide step.");

    a_error_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL_P |-> err_reg >= -11'sd768 && err_reg <= 11'sd768)
        else $error("Position error left its range.");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_left_count >= 11'd350 && m_left_count <= 11'd1150
                     && m_right_count >= 11'd350 && m_right_count <= 11'd1150)
        else $error("Servo count outside its range.");

    a_prev_error_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(prev_error_reg) |-> $past(state_reg == ST_DONE) && $past(!halt_reg))
        else $error("Previous error changed outside a steering transfer.");

endmodule
